>>> rtl/core/tcsw_pkg.sv
// Shared constants, types and codes of the text console scroll writer.
`default_nettype none

package tcsw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd2;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR = 2'd0,
        OP_PUT_CELL = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    // Command classes handed from the front end to the execution side.
    typedef enum logic [2:0] {
        K_PUT_CHAR = 3'd0,
        K_NEWLINE  = 3'd1,
        K_PUT_CELL = 3'd2,
        K_READ     = 3'd3,
        K_CLEAR    = 3'd4,
        K_NOP      = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   ch;
        logic [COLOR_W-1:0]  attr;
        logic [ADDR_W-1:0]   addr;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } t_be_ctl;

endpackage

`default_nettype wire

>>> rtl/core/text_console_scroll_writer_top.sv
// Top level of the text console scroll writer: front end, command queue and execution side.
//
// Usage: operations enter on the input channel (i_in_valid / o_in_ready) with fields
// operation, character, cell_color, column and line; one result per operation leaves
// on the output channel (o_out_valid / i_out_ready) with the cell read back, the cursor
// after the operation and a scroll flag. text_color is written through i_cfg_we and
// i_cfg_data, by the user only while the block is idle; the block itself does not enforce this.
// Path: a put-char, newline, put-cell or out-of-range operation passes the command queue
// and then the output register; a read also passes the registered memory read.
// Throughput: one such operation per cycle while the execution side is idle and results
// are taken. The cell memory has a single write port; through it a scroll copies the
// screen up one row and then zeroes the last row, and a clear writes every cell once.
// Operations keep queueing in the two-entry command queue meanwhile.
// Reset: the cursor homes, text_color returns to 0x02 and a fill pass writes a space in
// color 0x02 to every cell; no input is taken until it ends.
// Stall: a result waits in the output register while i_out_ready is low; the front end
// still takes operations until the queue is full.
`default_nettype none

module text_console_scroll_writer_top
    import tcsw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COLOR_W-1:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [CHAR_W-1:0]  i_character,
    input  wire logic [COLOR_W-1:0] i_cell_color,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [ROW_W-1:0]   i_line,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [CELL_W-1:0]       o_cell_value,
    output logic [COL_W-1:0]        o_cursor_column,
    output logic [ROW_W-1:0]        o_cursor_line,
    output logic                    o_scrolled
);

    t_be_ctl ctl;
    logic    cmd_valid;
    t_cmd    cmd;

    tcsw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_cell_color (i_cell_color),
        .i_column     (i_column),
        .i_line       (i_line),
        .i_ctl        (ctl),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    tcsw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_ctl           (ctl),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_value    (o_cell_value),
        .o_cursor_column (o_cursor_column),
        .o_cursor_line   (o_cursor_line),
        .o_scrolled      (o_scrolled)
    );

endmodule

`default_nettype wire

>>> rtl/core/tcsw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tcsw_front.sv
// Front end: accepts operations, classifies them and queues the commands.
`default_nettype none

module tcsw_front
    import tcsw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [CHAR_W-1:0]  i_character,
    input  wire logic [COLOR_W-1:0] i_cell_color,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [ROW_W-1:0]   i_line,
    input  wire t_be_ctl            i_ctl,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QPW-1:0]  r_wp, r_rp;
    logic [QCW-1:0]  r_cnt;
    t_cmd            cmd_in;
    logic            in_range;
    logic            push, pop, full;

    always_comb begin
        in_range = (int'(i_column) < SCREEN_WIDTH) && (int'(i_line) < SCREEN_HEIGHT);
        cmd_in.ch   = i_character;
        cmd_in.attr = i_cell_color;
        cmd_in.addr = ADDR_W'(i_line) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(i_column);
        unique case (t_op'(i_operation))
            OP_PUT_CHAR: cmd_in.kind = (i_character == NEWLINE_CODE) ? K_NEWLINE : K_PUT_CHAR;
            OP_PUT_CELL: cmd_in.kind = in_range ? K_PUT_CELL : K_NOP;
            OP_READ:     cmd_in.kind = in_range ? K_READ : K_NOP;
            OP_CLEAR:    cmd_in.kind = K_CLEAR;
            default:     cmd_in.kind = K_NOP;
        endcase
    end

    assign full        = (r_cnt == QCW'(QUEUE_DEPTH));
    assign o_in_ready  = !full && !i_ctl.init_busy;
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = i_ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> o_cmd_valid)
        else $error("command queue popped while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= QUEUE_DEPTH)
        else $error("command queue count past its depth");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tcsw_back.sv
// Execution side: cursor, cell memory sequencing for fill and scroll, result register.
`default_nettype none

module tcsw_back
    import tcsw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COLOR_W-1:0] i_cfg_data,
    input  wire logic               i_cmd_valid,
    input  wire t_cmd               i_cmd,
    output t_be_ctl                 o_ctl,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [CELL_W-1:0]       o_cell_value,
    output logic [COL_W-1:0]        o_cursor_column,
    output logic [ROW_W-1:0]        o_cursor_line,
    output logic                    o_scrolled
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_FILL = 5'b00100,
        ST_COPY = 5'b01000,
        ST_ZERO = 5'b10000
    } t_state;

    localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_WIDTH);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COLOR_W-1:0]  r_color;
    logic [CELL_W-1:0]   r_fill, n_fill;
    logic                r_emit, n_emit;
    logic                r_out_valid;
    logic [CELL_W-1:0]   r_out_cell;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic                r_out_scr;

    logic                load;
    logic [CELL_W-1:0]   load_cell;
    logic                load_scr;
    logic                pop, slot_free;
    logic                col_last, row_last, adv_row;
    logic [ADDR_W-1:0]   cur_addr;
    logic                we, re;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [CELL_W-1:0]   wdata, rdata;

    tcsw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign pop       = (r_state == ST_IDLE) && i_cmd_valid && slot_free;
    assign cur_addr  = ADDR_W'(r_row) * ROW_STEP + ADDR_W'(r_col);
    assign col_last  = (r_col == COL_W'(SCREEN_WIDTH - 1));
    assign row_last  = (r_row == ROW_W'(SCREEN_HEIGHT - 1));
    assign adv_row   = (i_cmd.kind == K_NEWLINE) || col_last;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_fill    = r_fill;
        n_emit    = r_emit;
        load      = 1'b0;
        load_cell = '0;
        load_scr  = 1'b0;
        we        = 1'b0;
        waddr     = r_cnt;
        wdata     = r_fill;
        re        = 1'b0;
        raddr     = i_cmd.addr;
        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.kind)
                        K_PUT_CHAR, K_NEWLINE: begin
                            if (i_cmd.kind == K_PUT_CHAR) begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = {r_color, i_cmd.ch};
                            end
                            if (!adv_row) begin
                                n_col = r_col + 1'b1;
                                load  = 1'b1;
                            end else begin
                                n_col = '0;
                                if (row_last) begin
                                    // The result waits until the screen has moved up.
                                    n_state = ST_COPY;
                                    n_cnt   = '0;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    load  = 1'b1;
                                end
                            end
                        end
                        K_PUT_CELL: begin
                            we    = 1'b1;
                            waddr = i_cmd.addr;
                            wdata = {i_cmd.attr, i_cmd.ch};
                            load  = 1'b1;
                        end
                        K_READ: begin
                            re      = 1'b1;
                            n_state = ST_READ;
                        end
                        K_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_fill  = {r_color, SPACE_CODE};
                            n_emit  = 1'b1;
                            n_cnt   = '0;
                            n_state = ST_FILL;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load      = 1'b1;
                load_cell = rdata;
                n_state   = ST_IDLE;
            end
            ST_FILL: begin
                we    = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_IDLE;
                    load    = r_emit;
                end
            end
            ST_COPY: begin
                // Read the cell one row below, write the previous read one row up.
                re    = (r_cnt != COPY_LAST);
                raddr = r_cnt + ROW_STEP;
                we    = (r_cnt != '0);
                waddr = r_cnt - 1'b1;
                wdata = rdata;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == COPY_LAST) begin
                    n_cnt   = COPY_LAST;
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                we    = 1'b1;
                wdata = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state  = ST_IDLE;
                    load     = 1'b1;
                    load_scr = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= RESET_COLOR;
            r_fill      <= {RESET_COLOR, SPACE_CODE};
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            if (i_cfg_we) begin
                r_color <= i_cfg_data;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_cell <= load_cell;
            r_out_col  <= n_col;
            r_out_row  <= n_row;
            r_out_scr  <= load_scr;
        end
    end

    assign o_ctl.pop       = pop;
    assign o_ctl.init_busy = (r_state == ST_FILL) && !r_emit;
    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_out_cell;
    assign o_cursor_column = r_out_col;
    assign o_cursor_line   = r_out_row;
    assign o_scrolled      = r_out_scr;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> slot_free)
        else $error("result loaded over an untaken result");
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_col) < SCREEN_WIDTH) && (int'(r_row) < SCREEN_HEIGHT))
        else $error("cursor left the screen");
    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_cnt <= COPY_LAST) && row_last)
        else $error("scroll copy ran past the last row");
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> o_out_valid)
        else $error("read finished without a result");
`endif

endmodule

`default_nettype wire

>>> verif/text_console_scroll_writer_top_tb.sv
// Self-checking testbench for the text console scroll writer, checked against a predicted screen.
`timescale 1ns / 1ps

module text_console_scroll_writer_top_tb;
    import tcsw_pkg::*;

    localparam int STALL_LIMIT      = 20000;
    localparam int SETTLE_CYCLES    = 2100;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int PHASE_COUNT      = 4;
    localparam int QUIET_FIRST      = 300;
    localparam int QUIET_LAST       = 450;

    typedef struct {
        t_op                op;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] color;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        bit                 drain_first;
    } t_console_cmd;

    typedef struct {
        logic [CELL_W-1:0] cell_val;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic              scrolled;
    } t_console_view;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [COLOR_W-1:0] i_cfg_data   = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_operation  = '0;
    logic [CHAR_W-1:0]  i_character  = '0;
    logic [COLOR_W-1:0] i_cell_color = '0;
    logic [COL_W-1:0]   i_column     = '0;
    logic [ROW_W-1:0]   i_line       = '0;
    logic               o_out_valid;
    logic               i_out_ready  = 1'b0;
    logic [CELL_W-1:0]  o_cell_value;
    logic [COL_W-1:0]   o_cursor_column;
    logic [ROW_W-1:0]   o_cursor_line;
    logic               o_scrolled;

    // Predicted screen contents, cursor and text color.
    logic [CELL_W-1:0]  screen_model [CELL_COUNT];
    int                 cursor_col_m;
    int                 cursor_row_m;
    logic [COLOR_W-1:0] text_color_m;

    t_console_cmd  cmd_queue[$];
    t_console_view view_queue[$];
    t_console_cmd  cmd_on_bus;
    bit            drain_mark   = 1'b0;
    int            sent_count   = 0;
    int            seen_count   = 0;
    int            error_count  = 0;
    int            stall_cycles = 0;

    text_console_scroll_writer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_character     (i_character),
        .i_cell_color    (i_cell_color),
        .i_column        (i_column),
        .i_line          (i_line),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_value    (o_cell_value),
        .o_cursor_column (o_cursor_column),
        .o_cursor_line   (o_cursor_line),
        .o_scrolled      (o_scrolled)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void fill_screen_model(logic [CELL_W-1:0] fill_val);
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_model[i] = fill_val;
        end
    endfunction

    // Cursor to column 0 of the next row; off the last row the screen moves up one line.
    function automatic bit step_row();
        cursor_col_m = 0;
        if (cursor_row_m + 1 >= SCREEN_HEIGHT) begin
            for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++) begin
                screen_model[i] = screen_model[i + SCREEN_WIDTH];
            end
            for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++) begin
                screen_model[i] = '0;
            end
            cursor_row_m = SCREEN_HEIGHT - 1;
            return 1'b1;
        end
        cursor_row_m++;
        return 1'b0;
    endfunction

    function automatic t_console_view apply_console_cmd(t_console_cmd c);
        t_console_view v;
        bit            in_range;
        int            addr;
        v.cell_val = '0;
        v.scrolled = 1'b0;
        in_range   = (c.col < SCREEN_WIDTH) && (c.row < SCREEN_HEIGHT);
        addr       = int'(c.row) * SCREEN_WIDTH + int'(c.col);
        case (c.op)
            OP_PUT_CHAR: begin
                if (c.ch == NEWLINE_CODE) begin
                    v.scrolled = step_row();
                end else begin
                    screen_model[cursor_row_m * SCREEN_WIDTH + cursor_col_m] =
                        {text_color_m, c.ch};
                    cursor_col_m++;
                    if (cursor_col_m >= SCREEN_WIDTH) begin
                        v.scrolled = step_row();
                    end
                end
            end
            OP_PUT_CELL: begin
                if (in_range) begin
                    screen_model[addr] = {c.color, c.ch};
                end
            end
            OP_READ: begin
                if (in_range) begin
                    v.cell_val = screen_model[addr];
                end
            end
            default: begin
                fill_screen_model({text_color_m, SPACE_CODE});
                cursor_col_m = 0;
                cursor_row_m = 0;
            end
        endcase
        v.cur_col = cursor_col_m[COL_W-1:0];
        v.cur_row = cursor_row_m[ROW_W-1:0];
        return v;
    endfunction

    function automatic void queue_cmd(t_op op, int unsigned ch, int unsigned color,
                                      int unsigned col, int unsigned row);
        t_console_cmd c;
        c.op          = op;
        c.ch          = ch[CHAR_W-1:0];
        c.color       = color[COLOR_W-1:0];
        c.col         = col[COL_W-1:0];
        c.row         = row[ROW_W-1:0];
        c.drain_first = drain_mark;
        drain_mark    = 1'b0;
        cmd_queue.push_back(c);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic wait_until_drained();
        while (cmd_queue.size() > 0 || view_queue.size() > 0 || i_in_valid) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: one command per transfer, with random gaps outside the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                view_queue.push_back(apply_console_cmd(cmd_on_bus));
                sent_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_queue.size() > 0 && !(cmd_queue[0].drain_first && view_queue.size() > 0)
                        && ((sent_count >= QUIET_FIRST && sent_count < QUIET_LAST)
                            || $urandom_range(0, 99) >= 18)) begin
                    cmd_on_bus = cmd_queue.pop_front();
                    i_operation  <= cmd_on_bus.op;
                    i_character  <= cmd_on_bus.ch;
                    i_cell_color <= cmd_on_bus.color;
                    i_column     <= cmd_on_bus.col;
                    i_line       <= cmd_on_bus.row;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compares every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_console_view want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen_count++;
                if (view_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual cell %0h cursor %0d,%0d",
                             $time, o_cell_value, o_cursor_column,
                             o_cursor_line);
                    error_count++;
                end else begin
                    want = view_queue.pop_front();
                    check_field("cell_value", 32'(want.cell_val), 32'(o_cell_value));
                    check_field("cursor_column", 32'(want.cur_col), 32'(o_cursor_column));
                    check_field("cursor_line", 32'(want.cur_row), 32'(o_cursor_line));
                    check_field("scrolled", 32'(want.scrolled), 32'(o_scrolled));
                end
            end
            i_out_ready <= (seen_count >= QUIET_FIRST && seen_count < QUIET_LAST)
                           || ($urandom_range(0, 99) >= 18);
        end
    end

    // The stall limit covers several scrolls or clears, each of which holds the block.
    always @(posedge i_clk) begin
        if (cmd_queue.size() > 0 || view_queue.size() > 0 || i_in_valid) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin
        int                 added;
        int                 kind;
        int                 n;
        int unsigned        ch;
        int unsigned        col;
        int unsigned        row;
        logic [COLOR_W-1:0] new_color;
        t_op                op;

        fill_screen_model({RESET_COLOR, SPACE_CODE});
        cursor_col_m = 0;
        cursor_row_m = 0;
        text_color_m = RESET_COLOR;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase > 0) begin
                wait_until_drained();
                // Give any stray extra result time to show up before the color changes.
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                new_color = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF
                                                                : 8'($urandom_range(0, 255));
                i_cfg_we     <= 1'b1;
                i_cfg_data   <= new_color;
                text_color_m = new_color;
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
            end else begin
                queue_cmd(OP_READ, $urandom, $urandom, 0, 0);
                queue_cmd(OP_PUT_CHAR, 'h41, $urandom, $urandom, $urandom);
                queue_cmd(OP_PUT_CHAR, 'h00, $urandom, $urandom, $urandom);
                queue_cmd(OP_PUT_CHAR, 'hFF, $urandom, $urandom, $urandom);
                queue_cmd(OP_PUT_CELL, 'hFF, 'hFF, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
                queue_cmd(OP_READ, $urandom, $urandom, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
                queue_cmd(OP_READ, $urandom, $urandom, 1, 0);
                queue_cmd(OP_PUT_CELL, 'h00, 'h00, 0, 0);
                queue_cmd(OP_READ, $urandom, $urandom, 0, 0);
                // Positions off the screen: writes are dropped, reads give zero.
                queue_cmd(OP_PUT_CELL, 'h5A, 'hA5, SCREEN_WIDTH, 0);
                queue_cmd(OP_PUT_CELL, 'h5A, 'hA5, 'h7F, 'h1F);
                queue_cmd(OP_READ, $urandom, $urandom, SCREEN_WIDTH, 0);
                queue_cmd(OP_READ, $urandom, $urandom, 0, SCREEN_HEIGHT);
                queue_cmd(OP_READ, $urandom, $urandom, 'h7F, 'h1F);
                queue_cmd(OP_PUT_CHAR, 32'(NEWLINE_CODE), $urandom, $urandom, $urandom);
                queue_cmd(OP_PUT_CELL, 'h55, 'hAA, 64, 16);
                queue_cmd(OP_READ, $urandom, $urandom, 64, 16);
                queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                queue_cmd(OP_READ, $urandom, $urandom, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
            end

            // Walk to the bottom: newlines off the last row, then a line that wraps there.
            queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
            for (int k = 0; k < SCREEN_HEIGHT + 1; k++) begin
                queue_cmd(OP_PUT_CHAR, 32'(NEWLINE_CODE), $urandom, $urandom, $urandom);
            end
            for (int k = 0; k < SCREEN_WIDTH + 5; k++) begin
                ch = $urandom_range(0, 255);
                if (ch == NEWLINE_CODE) begin
                    ch = 32'(SPACE_CODE);
                end
                queue_cmd(OP_PUT_CHAR, ch, $urandom, $urandom, $urandom);
            end
            queue_cmd(OP_READ, $urandom, $urandom, 0, SCREEN_HEIGHT - 1);
            queue_cmd(OP_READ, $urandom, $urandom, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
            queue_cmd(OP_READ, $urandom, $urandom, 3, SCREEN_HEIGHT - 2);
            added = SCREEN_HEIGHT + SCREEN_WIDTH + 10;

            drain_mark = 1'b1;
            while (added < RANDOM_PER_PHASE) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    // A run of text, sometimes long enough to wrap.
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100)
                                                    : $urandom_range(1, 20);
                    for (int k = 0; k < n; k++) begin
                        ch = $urandom_range(0, 255);
                        if ($urandom_range(0, 24) == 0) begin
                            ch = 32'(NEWLINE_CODE);
                        end
                        queue_cmd(OP_PUT_CHAR, ch, $urandom, $urandom, $urandom);
                    end
                end else if (kind < 60) begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) begin
                        queue_cmd(OP_PUT_CHAR, 32'(NEWLINE_CODE), $urandom, $urandom, $urandom);
                    end
                end else if (kind < 88) begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++) begin
                        op  = ($urandom_range(0, 1) == 0) ? OP_PUT_CELL : OP_READ;
                        col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SCREEN_WIDTH - 1)
                                                           : $urandom_range(0, 127);
                        row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SCREEN_HEIGHT - 1)
                                                           : $urandom_range(0, 31);
                        queue_cmd(op, $urandom, $urandom, col, row);
                    end
                end else if (kind < 91) begin
                    n = 1;
                    queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++) begin
                        op = t_op'($urandom_range(0, 3));
                        queue_cmd(op, $urandom, $urandom, $urandom, $urandom);
                    end
                end
                added += n;
                drain_mark = ($urandom_range(0, 49) == 0);
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tcsw_pkg.sv
rtl/core/tcsw_ram.sv
rtl/core/tcsw_front.sv
rtl/core/tcsw_back.sv
rtl/core/text_console_scroll_writer_top.sv
verif/text_console_scroll_writer_top_tb.sv
